### sv/skl_pkg.sv
// Shared constants, codes and types of the keyed list.
package skl_pkg;

  // List depth and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Field widths
  localparam int OP_W  = 3;
  localparam int POS_W = 7;
  localparam int ID_W  = 31;
  localparam int KEY_W = 37;
  localparam int ST_W  = 2;
  localparam int OUT_CNT_W = 7;

  // Width that holds both a position and a count
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Match encoder grouping
  localparam int GRP     = 8;
  localparam int GRP_W   = $clog2(GRP);
  localparam int NGRP    = (CAPACITY + GRP - 1) / GRP;
  localparam int PAD     = NGRP * GRP;

  // Operations
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;

  // Result status
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // Cell actions
  localparam logic [1:0] ACT_NOP = 2'd0;
  localparam logic [1:0] ACT_INS = 2'd1;
  localparam logic [1:0] ACT_DEL = 2'd2;
  localparam logic [1:0] ACT_WR  = 2'd3;

  // Command broadcast to every cell
  typedef struct packed {
    logic [1:0]       act;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } cell_cmd_t;

  // Outcome of the match scan
  typedef struct packed {
    logic             any;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
  } enc_res_t;

endpackage

### sv/sequential_keyed_list_top.sv
// Top level of the keyed list: sequencer, cell row, match encoder, result register.
//
// Packed ordered list of up to 64 records (id, key) kept in a row of cells,
// one record per cell. An item is taken only while the block is idle, so no
// new item is taken until the last one has executed. Each item passes the
// key compare in the cells, the three-stage registered first/last match
// encoder and then the execute state, where insert and remove shift the row
// from the target position onward. A result waiting in the output register
// stalls the execute state, not the earlier stages. Entry contents are not
// cleared by reset; only the entry count and the sequencer state are.
module sequential_keyed_list_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [skl_pkg::OP_W-1:0]      opcode,
  input  logic                          at_end,
  input  logic [skl_pkg::POS_W-1:0]     position,
  input  logic [skl_pkg::ID_W-1:0]      record_id,
  input  logic [skl_pkg::KEY_W-1:0]     record_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [skl_pkg::ST_W-1:0]      status,
  output logic [skl_pkg::ID_W-1:0]      found_id,
  output logic [skl_pkg::KEY_W-1:0]     found_key,
  output logic [skl_pkg::OUT_CNT_W-1:0] entry_count
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_ENC1  = 3'd2;
  localparam logic [2:0] S_ENC2  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0]                  state, state_next;
  logic [skl_pkg::CNT_W-1:0]   count;
  logic [skl_pkg::CNT_W-1:0]   count_next;
  logic [skl_pkg::OP_W-1:0]    cmd_op;
  logic                        cmd_at_end;
  logic [skl_pkg::POS_W-1:0]   cmd_pos;
  logic [skl_pkg::ID_W-1:0]    cmd_id;
  logic [skl_pkg::KEY_W-1:0]   cmd_key;

  skl_pkg::cell_cmd_t          cell_cmd;
  skl_pkg::enc_res_t           enc;
  logic [skl_pkg::ID_W-1:0]    cell_id  [skl_pkg::CAPACITY];
  logic [skl_pkg::KEY_W-1:0]   cell_key [skl_pkg::CAPACITY];
  logic [skl_pkg::PAD-1:0]     match;

  logic                        fire;
  logic [skl_pkg::CMP_W-1:0]   pos_ext, cnt_ext, ins_pos;
  logic [skl_pkg::IDX_W-1:0]   rd_idx;
  logic [skl_pkg::ID_W-1:0]    rd_id;
  logic [skl_pkg::KEY_W-1:0]   rd_key;
  logic [1:0]                  act;
  logic [skl_pkg::IDX_W-1:0]   act_pos;
  logic [skl_pkg::ST_W-1:0]    st_next;
  logic [skl_pkg::ID_W-1:0]    fid_next;
  logic [skl_pkg::KEY_W-1:0]   fkey_next;

  assign in_ready = (state == S_IDLE);
  assign fire     = (state == S_EXEC) && (!out_valid || out_ready);

  // Latch the command on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_op     <= opcode;
      cmd_at_end <= at_end;
      cmd_pos    <= position;
      cmd_id     <= record_id;
      cmd_key    <= record_key;
    end
  end

  // Broadcast the command to the row
  always_comb begin
    cell_cmd.act   = fire ? act : skl_pkg::ACT_NOP;
    cell_cmd.pos   = act_pos;
    cell_cmd.count = count;
    cell_cmd.id    = cmd_id;
    cell_cmd.key   = cmd_key;
  end

  // Row of cells, each handing records to its neighbors
  for (genvar i = 0; i < skl_pkg::CAPACITY; i++) begin : g_cell
    logic [skl_pkg::ID_W-1:0]  p_id, n_id;
    logic [skl_pkg::KEY_W-1:0] p_key, n_key;
    if (i == 0) begin : g_head
      assign p_id  = cmd_id;
      assign p_key = cmd_key;
    end else begin : g_body
      assign p_id  = cell_id[i-1];
      assign p_key = cell_key[i-1];
    end
    if (i == skl_pkg::CAPACITY - 1) begin : g_tail
      assign n_id  = cell_id[i];
      assign n_key = cell_key[i];
    end else begin : g_inner
      assign n_id  = cell_id[i+1];
      assign n_key = cell_key[i+1];
    end
    skl_cell u_cell (
      .clk      (clk),
      .idx      (skl_pkg::IDX_W'(i)),
      .cmd      (cell_cmd),
      .prev_id  (p_id),
      .prev_key (p_key),
      .next_id  (n_id),
      .next_key (n_key),
      .id       (cell_id[i]),
      .key      (cell_key[i]),
      .match    (match[i])
    );
  end

  if (skl_pkg::PAD > skl_pkg::CAPACITY) begin : g_pad
    assign match[skl_pkg::PAD-1:skl_pkg::CAPACITY] = '0;
  end

  skl_match_enc u_enc (
    .clk   (clk),
    .match (match),
    .res   (enc)
  );

  // Read mux over the row
  always_comb begin
    case (cmd_op)
      skl_pkg::OP_SEARCH: rd_idx = enc.first;
      skl_pkg::OP_REMOVE: rd_idx = enc.last;
      default:            rd_idx = cmd_pos[skl_pkg::IDX_W-1:0];
    endcase
    rd_id  = cell_id[rd_idx];
    rd_key = cell_key[rd_idx];
  end

  // Decide the result and the row action
  always_comb begin
    pos_ext    = skl_pkg::CMP_W'(cmd_pos);
    cnt_ext    = skl_pkg::CMP_W'(count);
    ins_pos    = cmd_at_end ? cnt_ext : pos_ext;
    act        = skl_pkg::ACT_NOP;
    act_pos    = cmd_pos[skl_pkg::IDX_W-1:0];
    st_next    = skl_pkg::ST_MISS;
    fid_next   = '0;
    fkey_next  = '0;
    count_next = count;
    case (cmd_op)
      skl_pkg::OP_INSERT: begin
        if (count == skl_pkg::CNT_W'(skl_pkg::CAPACITY)) begin
          st_next = skl_pkg::ST_FULL;
        end else if (ins_pos <= cnt_ext) begin
          st_next    = skl_pkg::ST_OK;
          act        = skl_pkg::ACT_INS;
          act_pos    = ins_pos[skl_pkg::IDX_W-1:0];
          count_next = count + 1'b1;
        end
      end
      skl_pkg::OP_SEARCH: begin
        if (enc.any) begin
          st_next   = skl_pkg::ST_OK;
          fid_next  = rd_id;
          fkey_next = rd_key;
        end
      end
      skl_pkg::OP_REMOVE: begin
        if (enc.any) begin
          st_next    = skl_pkg::ST_OK;
          fid_next   = rd_id;
          fkey_next  = rd_key;
          act        = skl_pkg::ACT_DEL;
          act_pos    = enc.last;
          count_next = count - 1'b1;
        end
      end
      skl_pkg::OP_READ: begin
        if (pos_ext < cnt_ext) begin
          st_next   = skl_pkg::ST_OK;
          fid_next  = rd_id;
          fkey_next = rd_key;
        end
      end
      skl_pkg::OP_UPDATE: begin
        if (pos_ext < cnt_ext) begin
          st_next = skl_pkg::ST_OK;
          act     = skl_pkg::ACT_WR;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence the stages
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_MATCH;
      S_MATCH: state_next = S_ENC1;
      S_ENC1:  state_next = S_ENC2;
      S_ENC2:  state_next = S_EXEC;
      S_EXEC:  if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (fire) count <= count_next;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status      <= st_next;
      found_id    <= fid_next;
      found_key   <= fkey_next;
      entry_count <= skl_pkg::OUT_CNT_W'(count_next);
    end
  end

endmodule

### sv/skl_cell.sv
// One list entry: holds a record, compares its key, shifts with its neighbors.
module skl_cell (
  input  logic                        clk,
  input  logic [skl_pkg::IDX_W-1:0]   idx,
  input  skl_pkg::cell_cmd_t          cmd,
  input  logic [skl_pkg::ID_W-1:0]    prev_id,
  input  logic [skl_pkg::KEY_W-1:0]   prev_key,
  input  logic [skl_pkg::ID_W-1:0]    next_id,
  input  logic [skl_pkg::KEY_W-1:0]   next_key,
  output logic [skl_pkg::ID_W-1:0]    id,
  output logic [skl_pkg::KEY_W-1:0]   key,
  output logic                        match
);

  // Flag a live entry whose key equals the command key
  assign match = (key == cmd.key) && (skl_pkg::CNT_W'(idx) < cmd.count);

  // Shift up on insert, down on remove, or overwrite in place
  always_ff @(posedge clk) begin
    case (cmd.act)
      skl_pkg::ACT_INS: begin
        if (idx == cmd.pos) begin
          id  <= cmd.id;
          key <= cmd.key;
        end else if (idx > cmd.pos) begin
          id  <= prev_id;
          key <= prev_key;
        end
      end
      skl_pkg::ACT_DEL: begin
        if (idx >= cmd.pos) begin
          id  <= next_id;
          key <= next_key;
        end
      end
      skl_pkg::ACT_WR: begin
        if (idx == cmd.pos) begin
          id  <= cmd.id;
          key <= cmd.key;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/skl_match_enc.sv
// Registered priority encoder over the cell match flags: first and last hit.
module skl_match_enc (
  input  logic                    clk,
  input  logic [skl_pkg::PAD-1:0] match,
  output skl_pkg::enc_res_t       res
);

  logic [skl_pkg::PAD-1:0]   match_q;
  logic [skl_pkg::NGRP-1:0]  grp_any, grp_any_q;
  logic [skl_pkg::GRP_W-1:0] grp_first   [skl_pkg::NGRP];
  logic [skl_pkg::GRP_W-1:0] grp_last    [skl_pkg::NGRP];
  logic [skl_pkg::GRP_W-1:0] grp_first_q [skl_pkg::NGRP];
  logic [skl_pkg::GRP_W-1:0] grp_last_q  [skl_pkg::NGRP];
  skl_pkg::enc_res_t         res_next;

  // Capture the flags
  always_ff @(posedge clk) begin
    match_q <= match;
  end

  // Encode each group of eight
  always_comb begin
    for (int g = 0; g < skl_pkg::NGRP; g++) begin
      grp_any[g]   = 1'b0;
      grp_first[g] = '0;
      grp_last[g]  = '0;
      for (int j = skl_pkg::GRP - 1; j >= 0; j--) begin
        if (match_q[g * skl_pkg::GRP + j]) grp_first[g] = skl_pkg::GRP_W'(j);
      end
      for (int j = 0; j < skl_pkg::GRP; j++) begin
        if (match_q[g * skl_pkg::GRP + j]) begin
          grp_last[g] = skl_pkg::GRP_W'(j);
          grp_any[g]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_q   <= grp_any;
    grp_first_q <= grp_first;
    grp_last_q  <= grp_last;
  end

  // Combine the groups
  always_comb begin
    res_next.any   = |grp_any_q;
    res_next.first = '0;
    res_next.last  = '0;
    for (int g = skl_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        res_next.first = skl_pkg::IDX_W'(g * skl_pkg::GRP + int'(grp_first_q[g]));
      end
    end
    for (int g = 0; g < skl_pkg::NGRP; g++) begin
      if (grp_any_q[g]) begin
        res_next.last = skl_pkg::IDX_W'(g * skl_pkg::GRP + int'(grp_last_q[g]));
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

### sim/tb_top.sv
// Self-checking testbench for the keyed list: random traffic, list predictor, result checks.
module tb_top;
  import skl_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT = 1000;
  localparam int QUIET_LO = 600;
  localparam int QUIET_HI = 800;
  localparam int IDLE_PCT = 29;
  localparam int POOL_N = 16;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [KEY_W-1:0] KEY_DEC_MAX = 37'd99999999999;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum int { PH_MIXED, PH_FILL, PH_DRAIN } traffic_phase_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             at_end;
    logic [POS_W-1:0] pos;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic             drain_first;
  } list_req_t;

  typedef struct packed {
    logic [ST_W-1:0]      st;
    logic [ID_W-1:0]      id;
    logic [KEY_W-1:0]     key;
    logic [OUT_CNT_W-1:0] cnt;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] opcode = '0;
  logic at_end = 1'b0;
  logic [POS_W-1:0] position = '0;
  logic [ID_W-1:0] record_id = '0;
  logic [KEY_W-1:0] record_key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ST_W-1:0] status;
  logic [ID_W-1:0] found_id;
  logic [KEY_W-1:0] found_key;
  logic [OUT_CNT_W-1:0] entry_count;

  // Predicted list contents
  logic [ID_W-1:0]  list_ids [CAPACITY];
  logic [KEY_W-1:0] list_keys [CAPACITY];
  int list_count = 0;

  list_req_t pending_reqs[$];
  list_rsp_t expected_rsps[$];
  logic [KEY_W-1:0] key_pool [POOL_N];

  int n_errors = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_ok = 0;
  int n_miss = 0;
  int n_full = 0;
  int peak_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycles = 0;

  sequential_keyed_list_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .at_end(at_end), .position(position),
    .record_id(record_id), .record_key(record_key),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .found_id(found_id), .found_key(found_key),
    .entry_count(entry_count)
  );

  // Clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Reset
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Apply one operation to the predicted list and return its result
  function automatic list_rsp_t predict_list_op(list_req_t r);
    list_rsp_t rsp;
    int p;
    int hit;
    int i;
    rsp.st = ST_MISS;
    rsp.id = '0;
    rsp.key = '0;
    hit = -1;
    case (r.op)
      OP_INSERT: begin
        p = r.at_end ? list_count : int'(r.pos);
        if (list_count >= CAPACITY) begin
          rsp.st = ST_FULL;
        end else if (p <= list_count) begin
          for (i = list_count; i > p; i--) begin
            list_ids[i] = list_ids[i-1];
            list_keys[i] = list_keys[i-1];
          end
          list_ids[p] = r.id;
          list_keys[p] = r.key;
          list_count++;
          rsp.st = ST_OK;
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < list_count; i++)
          if (hit < 0 && list_keys[i] == r.key) hit = i;
        if (hit >= 0) begin
          rsp.st = ST_OK;
          rsp.id = list_ids[hit];
          rsp.key = list_keys[hit];
        end
      end
      OP_REMOVE: begin
        for (i = 0; i < list_count; i++)
          if (list_keys[i] == r.key) hit = i;
        if (hit >= 0) begin
          rsp.st = ST_OK;
          rsp.id = list_ids[hit];
          rsp.key = list_keys[hit];
          for (i = hit; i + 1 < list_count; i++) begin
            list_ids[i] = list_ids[i+1];
            list_keys[i] = list_keys[i+1];
          end
          list_count--;
        end
      end
      OP_READ: begin
        if (int'(r.pos) < list_count) begin
          rsp.st = ST_OK;
          rsp.id = list_ids[r.pos];
          rsp.key = list_keys[r.pos];
        end
      end
      OP_UPDATE: begin
        if (int'(r.pos) < list_count) begin
          list_ids[r.pos] = r.id;
          list_keys[r.pos] = r.key;
          rsp.st = ST_OK;
        end
      end
      default: ;
    endcase
    rsp.cnt = list_count[OUT_CNT_W-1:0];
    if (list_count > peak_count) peak_count = list_count;
    if (rsp.st == ST_OK) n_ok++;
    else if (rsp.st == ST_FULL) n_full++;
    else n_miss++;
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
             n_checked, what, got, want);
    n_errors++;
  endtask

  function automatic list_req_t mk_req(logic [OP_W-1:0] op, logic tail, logic [POS_W-1:0] pos,
                                       logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
    list_req_t r;
    r.op = op;
    r.at_end = tail;
    r.pos = pos;
    r.id = id;
    r.key = key;
    r.drain_first = 1'b0;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] wide_key();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[KEY_W-1:0];
  endfunction

  // Mostly keys from a small pool so searches and removes hit
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_N-1)];
    return wide_key();
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 99) < 10) return raw[0] ? ID_MAX : '0;
    return raw[ID_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return POS_W'($urandom_range(0, 8));
    if (r < 80) return POS_W'($urandom_range(0, CAPACITY));
    return POS_W'($urandom_range(0, 127));
  endfunction

  // Operation mix depends on whether the list should grow, shrink or churn
  function automatic logic [OP_W-1:0] pick_op(traffic_phase_e ph);
    int r;
    int w_ins;
    int w_srch;
    int w_rem;
    int w_rd;
    int w_upd;
    case (ph)
      PH_FILL:  begin w_ins = 70; w_srch = 8;  w_rem = 8;  w_rd = 6;  w_upd = 6;  end
      PH_DRAIN: begin w_ins = 10; w_srch = 10; w_rem = 60; w_rd = 8;  w_upd = 8;  end
      default:  begin w_ins = 30; w_srch = 20; w_rem = 20; w_rd = 12; w_upd = 12; end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_ins) return OP_INSERT;
    r -= w_ins;
    if (r < w_srch) return OP_SEARCH;
    r -= w_srch;
    if (r < w_rem) return OP_REMOVE;
    r -= w_rem;
    if (r < w_rd) return OP_READ;
    r -= w_rd;
    if (r < w_upd) return OP_UPDATE;
    return OP_UNUSED_LO + OP_W'($urandom_range(0, 2));
  endfunction

  // Driver: offer queued operations, with random gaps
  always @(posedge clk) begin
    bit busy;
    bit idle;
    list_req_t rq;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) n_accepted++;
      if (!in_valid || in_ready) begin
        busy = pending_reqs.size() > 0 && pending_reqs[0].drain_first &&
               n_accepted != n_checked;
        idle = !(n_accepted >= QUIET_LO && n_accepted < QUIET_HI) &&
               $urandom_range(0, 99) < IDLE_PCT;
        if (pending_reqs.size() > 0 && !busy && !idle) begin
          rq = pending_reqs.pop_front();
          opcode <= rq.op;
          at_end <= rq.at_end;
          position <= rq.pos;
          record_id <= rq.id;
          record_key <= rq.key;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    list_req_t rq;
    list_rsp_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rq = mk_req(opcode, at_end, position, record_id, record_key);
        expected_rsps.push_back(predict_list_op(rq));
      end
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("result with nothing expected", 64'(status), 64'(0));
        end else begin
          want = expected_rsps.pop_front();
          if (status !== want.st)
            report_mismatch("status", 64'(status), 64'(want.st));
          if (found_id !== want.id)
            report_mismatch("found_id", 64'(found_id), 64'(want.id));
          if (found_key !== want.key)
            report_mismatch("found_key", 64'(found_key), 64'(want.key));
          if (entry_count !== want.cnt)
            report_mismatch("entry_count", 64'(entry_count), 64'(want.cnt));
        end
        n_checked++;
      end
      // Hold off once for a long stretch so the list backs up
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && n_checked >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      out_ready <= (hold_left == 0) &&
                   ((n_checked >= QUIET_LO && n_checked < QUIET_HI) ||
                    $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    traffic_phase_e plan [7];
    int plan_len [7];
    list_req_t rq;
    int ph;
    int k;
    plan = '{PH_MIXED, PH_FILL, PH_DRAIN, PH_MIXED, PH_FILL, PH_MIXED, PH_DRAIN};
    plan_len = '{200, 220, 200, 200, 220, 150, 210};
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    key_pool[2] = KEY_DEC_MAX;
    for (k = 3; k < POOL_N; k++) key_pool[k] = wide_key();

    // Empty list: every lookup misses
    pending_reqs.push_back(mk_req(OP_READ, 1'b0, '0, '0, '0));
    pending_reqs.push_back(mk_req(OP_SEARCH, 1'b0, '0, '0, '0));
    pending_reqs.push_back(mk_req(OP_REMOVE, 1'b0, '0, '0, '0));
    pending_reqs.push_back(mk_req(OP_UPDATE, 1'b0, '0, ID_MAX, KEY_MAX));
    // Append ignoring position, head insert, append by position, past the count
    pending_reqs.push_back(mk_req(OP_INSERT, 1'b1, POS_MAX, ID_MAX, KEY_MAX));
    pending_reqs.push_back(mk_req(OP_INSERT, 1'b0, 7'd0, '0, '0));
    pending_reqs.push_back(mk_req(OP_INSERT, 1'b0, 7'd2, 31'd5, KEY_DEC_MAX));
    pending_reqs.push_back(mk_req(OP_INSERT, 1'b0, 7'd5, 31'd9, 37'd9));
    // Duplicate key in the middle: search finds first, remove takes last
    pending_reqs.push_back(mk_req(OP_INSERT, 1'b0, 7'd1, 31'd7, KEY_MAX));
    pending_reqs.push_back(mk_req(OP_SEARCH, 1'b0, '0, '0, KEY_MAX));
    pending_reqs.push_back(mk_req(OP_READ, 1'b0, 7'd3, '0, '0));
    pending_reqs.push_back(mk_req(OP_READ, 1'b0, 7'd4, '0, '0));
    pending_reqs.push_back(mk_req(OP_READ, 1'b0, POS_MAX, '0, '0));
    pending_reqs.push_back(mk_req(OP_UPDATE, 1'b0, 7'd0, 31'h2AAAAAAA, 37'h0AAAAAAAAA));
    pending_reqs.push_back(mk_req(OP_UPDATE, 1'b0, 7'd4, ID_MAX, KEY_MAX));
    pending_reqs.push_back(mk_req(OP_REMOVE, 1'b0, '0, '0, KEY_MAX));
    pending_reqs.push_back(mk_req(OP_SEARCH, 1'b0, '0, '0, KEY_MAX));
    // Unused opcodes
    pending_reqs.push_back(mk_req(OP_UNUSED_LO, 1'b1, POS_MAX, ID_MAX, KEY_MAX));
    pending_reqs.push_back(mk_req(OP_UNUSED_LO + 3'd1, 1'b0, '0, ID_MAX, KEY_MAX));
    pending_reqs.push_back(mk_req(OP_UNUSED_LO + 3'd2, 1'b1, 7'd1, '0, '0));
    pending_reqs.push_back(mk_req(OP_READ, 1'b0, 7'd0, '0, '0));
    pending_reqs.push_back(mk_req(OP_INSERT, 1'b0, POS_MAX, 31'd3, 37'd3));
    pending_reqs.push_back(mk_req(OP_REMOVE, 1'b0, '0, '0, KEY_DEC_MAX));

    // Random phases; each one starts once the previous results are in
    for (ph = 0; ph < 7; ph++) begin
      for (k = 0; k < plan_len[ph]; k++) begin
        rq = mk_req(pick_op(plan[ph]), 1'($urandom_range(0, 1)), pick_pos(),
                    pick_id(), pick_key());
        rq.drain_first = (k == 0);
        pending_reqs.push_back(rq);
      end
    end

    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_rsps.size() != 0)
      report_mismatch("results never delivered", 64'(0), 64'(expected_rsps.size()));

    $display("Ran %0d list operations: %0d ok, %0d missed or out of range, %0d full.",
             n_checked, n_ok, n_miss, n_full);
    $display("Peak occupancy %0d of %0d entries, %0d mismatches.",
             peak_count, CAPACITY, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
